/* design/mm3_pkg.sv */
// Shared types, constants and helpers for the MurmurHash3 x86_32 hash block.
// Used by mm3_ctrl, mm3_dpath and murmur3_x86_32_hash_top; no dependencies.
`default_nettype none
package mm3_pkg;

   // Mixing constants
   localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2  = 32'h1b873593;
   localparam logic [31:0] MIX_ADD = 32'he6546b64;
   localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
   localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

   localparam int unsigned ROT_SCRAMBLE = 15;
   localparam int unsigned ROT_MIX      = 13;

   // Full word byte count
   localparam logic [2:0] FULL_COUNT = 3'd4;

   // Request tdata layout: data_word then byte_count, padded to bytes
   localparam int unsigned REQ_DATA_W  = 40;
   localparam int unsigned RSP_DATA_W  = 32;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;    // latch request, pick seed or running hash
      logic mul1;      // word times C1
      logic mul2;      // rotate, times C2
      logic mix;       // fold scrambled word into hash, count bytes
      logic fin1;      // xor length, shift-xor, times M1
      logic fin2;      // shift-xor, times M2
      logic load_rsp;  // final shift-xor into response register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last;      // request in flight closes the key
   } status_type;

   // Keep only the valid low bytes of a partial word
   function automatic logic [31:0] byte_mask(input logic [2:0] count);
      logic [31:0] m;
      case (count)
         3'd0:    m = 32'h0000_0000;
         3'd1:    m = 32'h0000_00ff;
         3'd2:    m = 32'h0000_ffff;
         3'd3:    m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] rotl15(input logic [31:0] v);
      return {v[31-ROT_SCRAMBLE:0], v[31:32-ROT_SCRAMBLE]};
   endfunction

   function automatic logic [31:0] rotl13(input logic [31:0] v);
      return {v[31-ROT_MIX:0], v[31:32-ROT_MIX]};
   endfunction

endpackage
`default_nettype wire

/* design/mm3_ctrl.sv */
// Sequencing state machine for the MurmurHash3 block.
// Drives mm3_dpath through mm3_pkg::cmd_type; owns the handshake flags.
`default_nettype none
module mm3_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire mm3_pkg::status_type status,
   output mm3_pkg::cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_MIX  = 3'd3;
   localparam logic [2:0] ST_FIN1 = 3'd4;
   localparam logic [2:0] ST_FIN2 = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = status.last ? ST_FIN1 : ST_IDLE;
         end
         ST_FIN1: begin
            cmd.fin1 = 1'b1;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            cmd.fin2 = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the response register is free
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A request always starts the scramble
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_MUL1))
      else $error("accepted request did not start scramble");

   // Never overwrite a response that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten while stalled");

   // A middle word returns straight to idle without a response
   a_mid_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX && !status.last) |=> (state_ff == ST_IDLE && !cmd.load_rsp))
      else $error("non-last word did not return to idle");

   // A loaded response is offered on the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_tvalid)
      else $error("loaded response not offered");

endmodule
`default_nettype wire

/* design/mm3_dpath.sv */
// Datapath for the MurmurHash3 block: seed, running hash, length, one shared
// 32x32 multiplier and the response register. Uses mm3_pkg; driven by mm3_ctrl.
`default_nettype none
module mm3_dpath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [mm3_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                              req_tlast,
   input  wire logic                              csr_valid,
   input  wire logic [31:0]                       csr_data,
   input  wire mm3_pkg::cmd_type                  cmd,
   output mm3_pkg::status_type                    status,
   output logic [mm3_pkg::RSP_DATA_W-1:0]         rsp_tdata
);

   logic [31:0] seed_ff;
   logic        key_active_ff;
   logic [31:0] word_ff;
   logic [2:0]  count_ff;
   logic        last_ff;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] prod_ff;
   logic [31:0] rsp_ff;

   logic [31:0] req_word;
   logic [2:0]  req_count, count_eff;
   logic [31:0] mul_a, mul_b, mul_p;
   logic [31:0] mix_x, mix_r, fin_a, fin_b;

   assign req_word  = req_tdata[31:0];
   assign req_count = req_tdata[34:32];

   // Middle words count as full; oversize counts saturate
   assign count_eff = (!req_tlast || req_count > mm3_pkg::FULL_COUNT) ?
                      mm3_pkg::FULL_COUNT : req_count;

   // Finalization operands
   assign fin_a = hash_ff ^ total_ff;
   assign fin_b = prod_ff ^ {13'd0, prod_ff[31:13]};

   // Shared multiplier, low 32 bits of the product
   always_comb begin
      if (cmd.mul2) begin
         mul_a = mm3_pkg::rotl15(prod_ff);
         mul_b = mm3_pkg::MIX_C2;
      end else if (cmd.fin1) begin
         mul_a = fin_a ^ {16'd0, fin_a[31:16]};
         mul_b = mm3_pkg::FIN_M1;
      end else if (cmd.fin2) begin
         mul_a = fin_b;
         mul_b = mm3_pkg::FIN_M2;
      end else begin
         mul_a = word_ff;
         mul_b = mm3_pkg::MIX_C1;
      end
   end
   assign mul_p = mul_a * mul_b;

   // Fold the scrambled word into the hash
   assign mix_x = hash_ff ^ prod_ff;
   assign mix_r = mm3_pkg::rotl13(mix_x);
   always_comb begin
      hash_in  = hash_ff;
      total_in = total_ff;
      if (cmd.accept && !key_active_ff) begin
         hash_in = seed_ff;
      end
      if (cmd.mix) begin
         total_in = total_ff + {29'd0, count_ff};
         if (count_ff == mm3_pkg::FULL_COUNT) begin
            hash_in = ({mix_r[29:0], 2'b00} + mix_r) + mm3_pkg::MIX_ADD;
         end else begin
            hash_in = mix_x;
         end
      end
      if (cmd.load_rsp) begin
         total_in = '0;
      end
   end

   // Control-like state: seed, key flag, length
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= '0;
         key_active_ff <= 1'b0;
         total_ff      <= '0;
      end else begin
         if (csr_valid) begin
            seed_ff <= csr_data;
         end
         if (cmd.mix) begin
            key_active_ff <= !last_ff;
         end
         total_ff <= total_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         word_ff  <= req_word & mm3_pkg::byte_mask(count_eff);
         count_ff <= count_eff;
         last_ff  <= req_tlast;
      end
      if (cmd.mul1 || cmd.mul2 || cmd.fin1 || cmd.fin2) begin
         prod_ff <= mul_p;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= prod_ff ^ {16'd0, prod_ff[31:16]};
      end
      hash_ff <= hash_in;
   end

   assign status.last = last_ff;
   assign rsp_tdata   = rsp_ff;

endmodule
`default_nettype wire

/* design/murmur3_x86_32_hash_top.sv */
// Top level of the MurmurHash3 x86_32 hash block.
// Instantiates mm3_ctrl and mm3_dpath; uses mm3_pkg.
//
// Usage: a key streams in on req_ as 32-bit words of little-endian bytes,
// first byte in bits 7:0. req_tdata[34:32] gives the valid byte count, which
// only matters on the word marked by req_tlast; earlier words count as four
// bytes. An empty key is one last word with count zero. The finished hash
// leaves on rsp_ as one response per key.
// The seed is written through csr_valid/csr_data between keys; a key picks
// up the seed present when its first word is accepted.
// Sequence: each word goes through accept, two multiplies and mix; the last
// word adds two finalization multiplies and the response load, which waits
// for a free response register. All multiplies share one 32x32 multiplier,
// so a new word is taken only after the one before has finished its mix.
// The finished hash sits in an output register; if the receiver stalls, the
// next key is still taken and worked up to its final hash, which waits
// until the earlier response leaves.
// Reset (synchronous, active high) clears the seed to zero, drops any
// partial key and any pending response.
`default_nettype none
module murmur3_x86_32_hash_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
   input  wire logic        req_tlast,   // last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] hash
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data     // seed
);

   mm3_pkg::cmd_type    cmd;
   mm3_pkg::status_type status;

   // Seed writes are always taken
   assign csr_ready = 1'b1;

   mm3_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mm3_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire

/* tb/murmur3_x86_32_hash_top_tb.sv */
// Testbench for the streaming MurmurHash3 x86_32 hash block: keys as word streams, seed writes.
// Needs only murmur3_x86_32_hash_top and its package; predicts every hash and checks in order.
`timescale 1ns / 1ps
module murmur3_x86_32_hash_top_tb;

   localparam logic [31:0] SCRAMBLE_M1 = 32'hcc9e2d51;
   localparam logic [31:0] SCRAMBLE_M2 = 32'h1b873593;
   localparam logic [31:0] CHAIN_ADD   = 32'he6546b64;
   localparam logic [31:0] AVAL_M1     = 32'h85ebca6b;
   localparam logic [31:0] AVAL_M2     = 32'hc2b2ae35;
   localparam logic [2:0]  WORD_BYTES  = 3'd4;
   // Cycles for a word in flight to finish; the block has no output for non-last words
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_PHASE_WORDS = 225;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [31:0] data_word, [34:32] byte_count, rest zero
   logic        req_tlast = 1'b0; // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] hash
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;    // seed

   // Hash model state, mirrored from accepted requests and seed writes
   logic [31:0] seed_reg = '0;
   logic [31:0] key_hash = '0;
   logic [31:0] key_bytes = '0;
   logic        key_open = 1'b0;
   logic [31:0] expected_hashes[$];

   int mismatch_count = 0;
   int hashes_checked = 0;
   int words_sent = 0;
   int keys_sent = 0;
   int seed_writes = 0;
   bit sender_gaps_on = 1'b0;
   bit receiver_stalls_on = 1'b0;
   int stall_left = 0;

   murmur3_x86_32_hash_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Hard stop if the handshakes hang
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [31:0] rotate_left(input logic [31:0] v, input int unsigned r);
      return (v << r) | (v >> (32 - r));
   endfunction

   function automatic logic [31:0] scramble_word(input logic [31:0] k);
      logic [31:0] t;
      t = k * SCRAMBLE_M1;
      t = rotate_left(t, 15);
      return t * SCRAMBLE_M2;
   endfunction

   function automatic logic [31:0] avalanche(input logic [31:0] h);
      logic [31:0] t;
      t = h ^ (h >> 16);
      t = t * AVAL_M1;
      t = t ^ (t >> 13);
      t = t * AVAL_M2;
      return t ^ (t >> 16);
   endfunction

   // Track seed writes, fold accepted words into the model, check each hash
   always @(posedge clock) begin : hash_model
      logic [31:0] h;
      logic [31:0] want;
      logic [2:0]  n;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hashes.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected hash %h", $realtime, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_hashes.pop_front();
               hashes_checked++;
               if (rsp_tdata !== want) begin
                  if (mismatch_count < 10)
                     $display("%0t: hash mismatch, expected %h, got %h",
                              $realtime, want, rsp_tdata);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready)
            seed_reg = csr_data;
         if (req_tvalid && req_tready) begin
            n = req_tdata[34:32];
            if (!req_tlast || n > WORD_BYTES)
               n = WORD_BYTES;
            h = key_open ? key_hash : seed_reg;
            if (n == WORD_BYTES) begin
               h = h ^ scramble_word(req_tdata[31:0]);
               h = rotate_left(h, 13);
               h = h * 32'd5 + CHAIN_ADD;
            end else if (n != 3'd0) begin
               h = h ^ scramble_word(req_tdata[31:0] & ((32'd1 << (8 * n)) - 32'd1));
            end
            key_bytes = key_bytes + n;
            if (!req_tlast) begin
               key_hash = h;
               key_open = 1'b1;
            end else begin
               expected_hashes.push_back(avalanche(h ^ key_bytes));
               key_open = 1'b0;
               key_bytes = '0;
            end
         end
      end
   end

   // Receiver backpressure in random bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (receiver_stalls_on && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Drop valid and hold for a number of cycles
   task automatic hold_req(input int cycles);
      req_tvalid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Send one key word; leaves valid high so back-to-back requests stay gapless
   task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                            input logic is_last);
      if (sender_gaps_on && $urandom_range(0, 7) == 0)
         hold_req($urandom_range(1, 15));
      req_tdata = {5'b0, count, word};
      req_tlast = is_last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      words_sent++;
      if (is_last)
         keys_sent++;
   endtask

   // Pause the sender until every hash is back and the block has settled
   task automatic wait_drain();
      hold_req(0);
      while (expected_hashes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      seed_writes++;
   endtask

   // Short keys under the reset seed: every tail size, junk above the tail, saturated counts
   task automatic test_reset_seed_keys();
      send_word(32'hffffffff, 3'd0, 1'b1);
      send_word(32'hdeadbeab, 3'd1, 1'b1);
      send_word(32'hffffffff, 3'd2, 1'b1);
      send_word(32'h00000000, 3'd3, 1'b1);
      send_word(32'hffffffff, 3'd4, 1'b1);
      send_word(32'h00000000, 3'd0, 1'b0);
      send_word(32'hffffffff, 3'd7, 1'b1);
      send_word(32'h12345678, 3'd7, 1'b0);
      send_word(32'h9abcdef0, 3'd5, 1'b1);
      send_word(32'h80000001, 3'd6, 1'b1);
   endtask

   // Extreme seeds, and a seed change in the middle of a key
   task automatic test_seed_changes();
      wait_drain();
      write_seed(32'hffffffff);
      send_word(32'h00000000, 3'd0, 1'b1);
      send_word(32'h55aa55aa, 3'd4, 1'b0);
      send_word(32'haa55aa55, 3'd3, 1'b1);
      send_word(32'h01020304, 3'd4, 1'b0);
      wait_drain();
      write_seed(32'h00000000);
      send_word(32'h05060708, 3'd2, 1'b1);
      send_word(32'hcafef00d, 3'd4, 1'b1);
   endtask

   // Random keys, mostly short, now and then long; noise in non-last counts
   task automatic test_random_keys(input logic [31:0] seed, input bit with_idling);
      int sent;
      int len;
      logic [2:0] tail;
      wait_drain();
      write_seed(seed);
      sender_gaps_on = with_idling;
      receiver_stalls_on = with_idling;
      sent = 0;
      while (sent < RANDOM_PHASE_WORDS) begin
         if (with_idling) begin
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
         tail = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
         for (int i = 1; i < len; i++)
            send_word($urandom, ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                            : WORD_BYTES, 1'b0);
         send_word($urandom, tail, 1'b1);
         sent += len;
      end
      sender_gaps_on = 1'b0;
      receiver_stalls_on = 1'b0;
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;
      test_reset_seed_keys();
      test_seed_changes();
      test_random_keys($urandom, 1'b1);
      test_random_keys(32'hffffffff, 1'b1);
      test_random_keys(32'h00000000, 1'b1);
      test_random_keys($urandom, 1'b0);
      // Let the last hashes out, with a bound
      hold_req(0);
      for (int i = 0; i < 5000 && expected_hashes.size() != 0; i++) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Streamed %0d words as %0d keys under %0d seed writes; %0d hashes compared.",
               words_sent, keys_sent, seed_writes, hashes_checked);
      $display("Mismatches or unexpected hashes: %0d, hashes still owed: %0d.",
               mismatch_count, expected_hashes.size());
      if (mismatch_count == 0 && expected_hashes.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* files.f */
design/mm3_pkg.sv
design/mm3_ctrl.sv
design/mm3_dpath.sv
design/murmur3_x86_32_hash_top.sv
tb/murmur3_x86_32_hash_top_tb.sv
